// ----- rtl/lcg48_range_draw_defines.svh -----
// Assertion macros for the checker file of the range draw block.
`ifndef LCG48_RANGE_DRAW_DEFINES_SVH
`define LCG48_RANGE_DRAW_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst is high.
`define LRD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off while rst is high.
`define LRD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/lrd_pkg.sv -----
// Types and constants shared by the range draw block.
`timescale 1ns / 1ps
package lrd_pkg;

  // Opcodes of an input item
  localparam logic OP_DRAW   = 1'b0;
  localparam logic OP_RESEED = 1'b1;

  // Generator constants
  localparam logic [31:0] LCG_MULT_LO = 32'hDEEC_E66D;
  localparam logic [31:0] LCG_MULT_HI = 32'h0000_0005;
  localparam logic [47:0] LCG_ADD     = 48'h0000_0000_000B;
  localparam logic [47:0] STATE_RESET = 48'h1234_ABCD_330E;

  // Reseed mixing constants
  localparam logic [31:0] MIX_MULT   = 32'd1103515245;
  localparam logic [63:0] SEED_RESET = 64'd1;

  // One input item
  typedef struct packed {
    logic        opcode;
    logic [63:0] low_bound;
    logic [63:0] high_bound;
    logic [31:0] instance_number;
  } lrd_item_t;

  // Core status toward the top level
  typedef struct packed {
    logic idle;
    logic done;
  } lrd_stat_t;

endpackage

// ----- rtl/lrd_mul.sv -----
// Shared 32 x 32 multiplier with a registered product.
`timescale 1ns / 1ps
module lrd_mul (
  input  logic        clk,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [63:0] p
);

  // Register the full product
  always_ff @(posedge clk) begin
    p <= {32'b0, a} * {32'b0, b};
  end

endmodule

// ----- rtl/lrd_core.sv -----
// Sequencer and datapath: generator step, range scaling and reseed mixing.
`timescale 1ns / 1ps
module lrd_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  lrd_pkg::lrd_item_t item,
  input  logic [63:0]       seed_word,
  input  logic              res_ready,
  output lrd_pkg::lrd_stat_t stat,
  output logic [63:0]       res
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_LCG,
    S_SCALE,
    S_ADD,
    S_CLAMP,
    S_SEED,
    S_DONE
  } state_t;

  state_t       state;
  logic [2:0]   step;
  logic [47:0]  gen_state;
  logic [63:0]  lower;
  logic [63:0]  upper;
  logic [63:0]  delta;
  logic         full;
  logic [31:0]  inst;
  logic [111:0] acc;

  logic [31:0]  mul_a;
  logic [31:0]  mul_b;
  logic [63:0]  p;

  logic [63:0]  diff;
  logic [63:0]  offset;
  logic [15:0]  w0;
  logic [15:0]  w1;
  logic [15:0]  w2;
  logic         lo_lt_hi;

  lrd_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (p)
  );

  // Select multiplier operands for the current step
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      S_LCG: begin
        case (step)
          3'd0: begin mul_a = gen_state[31:0];           mul_b = lrd_pkg::LCG_MULT_LO; end
          3'd1: begin mul_a = gen_state[31:0];           mul_b = lrd_pkg::LCG_MULT_HI; end
          3'd2: begin mul_a = {16'b0, gen_state[47:32]}; mul_b = lrd_pkg::LCG_MULT_LO; end
          default: ;
        endcase
      end
      S_SCALE: begin
        case (step)
          3'd0: begin mul_a = gen_state[31:0];           mul_b = delta[31:0];  end
          3'd1: begin mul_a = gen_state[31:0];           mul_b = delta[63:32]; end
          3'd2: begin mul_a = {16'b0, gen_state[47:32]}; mul_b = delta[31:0];  end
          3'd3: begin mul_a = {16'b0, gen_state[47:32]}; mul_b = delta[63:32]; end
          default: ;
        endcase
      end
      S_SEED: begin
        case (step)
          3'd0: begin mul_a = seed_word[31:0];  mul_b = lrd_pkg::MIX_MULT; end
          3'd1: begin mul_a = seed_word[63:32]; mul_b = lrd_pkg::MIX_MULT; end
          3'd2: begin mul_a = inst;             mul_b = lrd_pkg::MIX_MULT; end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  // Range width, offset and the folded reseed words
  always_comb begin
    lo_lt_hi = item.low_bound < item.high_bound;
    diff     = upper - lower;
    offset   = full ? {gen_state, 16'b0} : acc[111:48];
    // acc holds m, p holds the instance mix l
    w0 = acc[15:0] ^ acc[39:24] ^ acc[63:48] ^ {8'b0, p[7:0]};
    w1 = acc[23:8] ^ acc[47:32] ^ {8'b0, acc[63:56]} ^ {8'b0, p[15:8]};
    w2 = acc[31:16] ^ acc[55:40] ^ p[31:16];
  end

  // Sequencer and registered results
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      step      <= '0;
      gen_state <= lrd_pkg::STATE_RESET;
    end else begin
      unique case (state)
        S_IDLE: begin
          step <= '0;
          if (start) begin
            inst <= item.instance_number;
            if (item.opcode == lrd_pkg::OP_RESEED) begin
              state <= S_SEED;
            end else if (item.low_bound == item.high_bound) begin
              res   <= item.low_bound;
              state <= S_DONE;
            end else begin
              lower <= lo_lt_hi ? item.low_bound : item.high_bound;
              upper <= lo_lt_hi ? item.high_bound : item.low_bound;
              state <= S_LCG;
            end
          end
        end
        S_LCG: begin
          step <= step + 3'd1;
          case (step)
            3'd0: begin
              delta <= diff + 64'd1;
              full  <= &diff;
            end
            3'd1: acc <= {48'b0, p};
            3'd2: acc[47:32] <= acc[47:32] + p[15:0];
            default: begin
              gen_state <= acc[47:0] + {p[15:0], 32'b0} + lrd_pkg::LCG_ADD;
              step      <= '0;
              state     <= full ? S_ADD : S_SCALE;
            end
          endcase
        end
        S_SCALE: begin
          step <= step + 3'd1;
          case (step)
            3'd0: ;
            3'd1: acc <= {48'b0, p};
            3'd2, 3'd3: acc <= acc + {16'b0, p, 32'b0};
            default: begin
              acc   <= acc + {p[47:0], 64'b0};
              step  <= '0;
              state <= S_ADD;
            end
          endcase
        end
        S_ADD: begin
          res   <= lower + offset;
          state <= S_CLAMP;
        end
        S_CLAMP: begin
          if (res > upper) begin
            res <= upper;
          end
          state <= S_DONE;
        end
        S_SEED: begin
          step <= step + 3'd1;
          case (step)
            3'd0: ;
            3'd1: acc <= {48'b0, p};
            3'd2: acc[63:32] <= acc[63:32] + p[31:0];
            default: begin
              gen_state <= {w2, w1, w0};
              res       <= '0;
              step      <= '0;
              state     <= S_DONE;
            end
          endcase
        end
        S_DONE: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign stat.idle = (state == S_IDLE);
  assign stat.done = (state == S_DONE);

endmodule

// ----- rtl/lcg48_range_draw.sv -----
// Top level of the rand48 range draw block: stream ports, seed register, output stage.
//
//   channel | dir | handshake          | content
//   s_*     | in  | s_tvalid/s_tready  | opcode, bounds, instance number
//   m_*     | out | m_tvalid/m_tready  | drawn value
//   cfg_*   | in  | cfg_we             | seed word
//
// A draw passes from accept to output valid through the generator step (three passes of the
// shared 32x32 multiplier), range scaling (four passes), add, clamp and the output register.
// A full 64-bit range skips the scaling, a reseed mixes the seed word into a new state,
// equal bounds go right out. Reset (rst, synchronous) loads the default state and a seed of 1.
// One item is in work at a time; a waiting result sits in the output register
// while the next item is accepted, and a stalled output holds the core.
`timescale 1ns / 1ps
module lcg48_range_draw (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [159:0] s_tdata,   // low_bound[63:0], high_bound[127:64], instance_number[159:128]
  input  logic [0:0]   s_tuser,   // opcode[0]
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [63:0]  m_tdata,   // value[63:0]
  input  logic         cfg_we,
  input  logic [63:0]  cfg_wdata
);

  lrd_pkg::lrd_item_t item;
  lrd_pkg::lrd_stat_t stat;
  logic [63:0]        seed_word;
  logic [63:0]        res;
  logic               out_free;
  logic               start;

  // Unpack the input item
  assign item.opcode          = s_tuser[0];
  assign item.low_bound       = s_tdata[63:0];
  assign item.high_bound      = s_tdata[127:64];
  assign item.instance_number = s_tdata[159:128];

  assign s_tready = stat.idle;
  assign start    = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  // Hold the seed word
  always_ff @(posedge clk) begin
    if (rst) begin
      seed_word <= lrd_pkg::SEED_RESET;
    end else if (cfg_we) begin
      seed_word <= cfg_wdata;
    end
  end

  lrd_core u_core (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .item      (item),
    .seed_word (seed_word),
    .res_ready (out_free),
    .stat      (stat),
    .res       (res)
  );

  // Output register: load a finished item, drop valid once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= stat.done;
      if (stat.done) begin
        m_tdata <= res;
      end
    end
  end

endmodule

// ----- rtl/lrd_checker.sv -----
// Port-level checks for the range draw block, bound to its top level.
`timescale 1ns / 1ps
`include "lcg48_range_draw_defines.svh"
module lrd_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [63:0] m_tdata
);

  // A stalled result holds its value
  `LRD_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled result changed")

  // One item at a time: ready drops right after an accept
  `LRD_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready, "ready stayed high after accept")

  // A new result only appears while the core was busy
  `LRD_ASSERT_NOW(a_result_from_work, $rose(m_tvalid), $past(!s_tready), "result appeared from idle core")

endmodule

bind lcg48_range_draw lrd_checker u_lrd_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
